// ===== src/rfpe_pkg.sv =====
package rfpe_pkg;

  localparam int TE_W    = 12;
  localparam int PRE_W   = 6;
  localparam int LEN_W   = 8;
  localparam int BITS_W  = 7;
  localparam int DUR_W   = 15;
  localparam int CNT_W   = 11;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int PROD_W  = TE_W + LEN_W;

  localparam logic [TE_W-1:0]   TE_RST       = 12'd400;
  localparam logic [PRE_W-1:0]  PRE_RST      = 6'd23;
  localparam logic [LEN_W-1:0]  HDR_RST      = 8'd10;
  localparam logic [LEN_W-1:0]  GRD_RST      = 8'd39;
  localparam logic [BITS_W-1:0] BITS_RST     = 7'd66;
  localparam logic [PRE_W-1:0]  PREAMBLE_MAX = 6'd48;
  localparam logic [PROD_W-1:0] DUR_MAX      = 20'h07FFF;

  localparam logic [CIDX_W-1:0] CFG_TE       = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_PREAMBLE = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HEADER   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_GUARD    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_BITS     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_LIM = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_HDR,
    S_BHI,
    S_BLO,
    S_GRD
  } state_t;

  typedef enum logic [2:0] {
    PK_PRE,
    PK_HDR,
    PK_BHI,
    PK_BLO,
    PK_GRD
  } pulse_kind_t;

  typedef struct packed {
    logic        accept;
    logic        emit;
    pulse_kind_t kind;
    logic        finish;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic first;
    logic pre_zero;
    logic pre_last;
    logic last_bit;
    logic slot_free;
    logic err;
  } dp_stat_t;

endpackage

// ===== src/rfpe_ctrl.sv =====
module rfpe_ctrl import rfpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.skip) begin
          if (!stat.first) begin
            state_nxt = S_BHI;
          end else if (stat.pre_zero) begin
            state_nxt = S_HDR;
          end else begin
            state_nxt = S_PRE;
          end
        end
      end
      S_PRE: begin
        if (stat.slot_free) begin
          if (stat.err) begin
            state_nxt = S_IDLE;
          end else if (stat.pre_last) begin
            state_nxt = S_HDR;
          end
        end
      end
      S_HDR: begin
        if (stat.slot_free) begin
          state_nxt = stat.err ? S_IDLE : S_BHI;
        end
      end
      S_BHI: begin
        if (stat.slot_free) begin
          state_nxt = stat.err ? S_IDLE : S_BLO;
        end
      end
      S_BLO: begin
        if (stat.slot_free) begin
          state_nxt = (!stat.err && stat.last_bit) ? S_GRD : S_IDLE;
        end
      end
      S_GRD: begin
        if (stat.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = PK_PRE;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_PRE: begin
        cmd.emit   = 1'b1;
        cmd.kind   = PK_PRE;
        cmd.finish = stat.slot_free && stat.err;
      end
      S_HDR: begin
        cmd.emit   = 1'b1;
        cmd.kind   = PK_HDR;
        cmd.finish = stat.slot_free && stat.err;
      end
      S_BHI: begin
        cmd.emit   = 1'b1;
        cmd.kind   = PK_BHI;
        cmd.finish = stat.slot_free && stat.err;
      end
      S_BLO: begin
        cmd.emit   = 1'b1;
        cmd.kind   = PK_BLO;
        cmd.finish = stat.slot_free && (stat.err || !stat.last_bit);
      end
      S_GRD: begin
        cmd.emit   = 1'b1;
        cmd.kind   = PK_GRD;
        cmd.finish = stat.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== src/rfpe_dp.sv =====
module rfpe_dp import rfpe_pkg::*; #(
  parameter int PULSE_LIMIT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [TE_W-1:0]   cfg_data,
  input  logic              in_data_bit,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_level,
  output logic [DUR_W-1:0]  out_length_us,
  output logic [STAT_W-1:0] out_status,
  output logic              out_run_last,
  output logic              out_frame_done,
  output logic [CNT_W-1:0]  out_pulses_so_far
);

  logic [TE_W-1:0]   te_us_r;
  logic [PRE_W-1:0]  preamble_len_r;
  logic [LEN_W-1:0]  header_len_r;
  logic [LEN_W-1:0]  guard_len_r;
  logic [BITS_W-1:0] frame_bits_r;

  logic [BITS_W-1:0] bit_pos_r;
  logic [CNT_W-1:0]  pulse_total_r;
  logic              skip_r;
  logic [PRE_W-1:0]  pre_idx_r;
  logic              bit_r;

  logic              out_valid_r;
  logic              out_level_r;
  logic [DUR_W-1:0]  out_dur_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_run_last_r;
  logic              out_done_r;
  logic [CNT_W-1:0]  out_cnt_r;

  logic [BITS_W-1:0] bit_next;
  logic              last_bit;
  logic [PRE_W-1:0]  np;
  logic [LEN_W-1:0]  te_units;
  logic [PROD_W-1:0] dur_full;
  logic              err_dur;
  logic              err_lim;
  logic              slot_free;
  logic              fire;
  logic              pulse_level;

  assign bit_next  = bit_pos_r + 7'd1;
  assign last_bit  = (bit_next == frame_bits_r);
  assign np        = (preamble_len_r > PREAMBLE_MAX) ? PREAMBLE_MAX : preamble_len_r;
  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = cmd.emit && slot_free;

  always_comb begin
    case (cmd.kind)
      PK_PRE: begin
        te_units    = 8'd1;
        pulse_level = ~pre_idx_r[0];
      end
      PK_HDR: begin
        te_units    = header_len_r;
        pulse_level = 1'b0;
      end
      PK_BHI: begin
        te_units    = bit_r ? 8'd2 : 8'd1;
        pulse_level = 1'b1;
      end
      PK_BLO: begin
        te_units    = bit_r ? 8'd1 : 8'd2;
        pulse_level = 1'b0;
      end
      PK_GRD: begin
        te_units    = guard_len_r;
        pulse_level = 1'b0;
      end
      default: begin
        te_units    = 8'd0;
        pulse_level = 1'b0;
      end
    endcase
  end

  assign dur_full = PROD_W'(te_units) * PROD_W'(te_us_r);
  assign err_dur  = (dur_full > DUR_MAX);
  assign err_lim  = (pulse_total_r >= CNT_W'(PULSE_LIMIT));

  always_comb begin
    stat           = '0;
    stat.skip      = skip_r;
    stat.first     = (bit_pos_r == '0);
    stat.pre_zero  = (np == '0);
    stat.pre_last  = ((pre_idx_r + 6'd1) == np);
    stat.last_bit  = last_bit;
    stat.slot_free = slot_free;
    stat.err       = err_dur || err_lim;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_us_r        <= TE_RST;
      preamble_len_r <= PRE_RST;
      header_len_r   <= HDR_RST;
      guard_len_r    <= GRD_RST;
      frame_bits_r   <= BITS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TE:       te_us_r        <= cfg_data;
        CFG_PREAMBLE: preamble_len_r <= cfg_data[PRE_W-1:0];
        CFG_HEADER:   header_len_r   <= cfg_data[LEN_W-1:0];
        CFG_GUARD:    guard_len_r    <= cfg_data[LEN_W-1:0];
        CFG_BITS:     frame_bits_r   <= cfg_data[BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r     <= '0;
      pulse_total_r <= '0;
      skip_r        <= 1'b0;
      pre_idx_r     <= '0;
    end else begin
      if (cmd.accept) begin
        if (skip_r) begin
          if (last_bit) begin
            bit_pos_r     <= '0;
            pulse_total_r <= '0;
            skip_r        <= 1'b0;
          end else begin
            bit_pos_r <= bit_next;
          end
        end else if (bit_pos_r == '0) begin
          pulse_total_r <= '0;
          pre_idx_r     <= '0;
        end
      end
      if (fire && !err_dur && !err_lim) begin
        if (!(cmd.finish && last_bit)) begin
          pulse_total_r <= pulse_total_r + 11'd1;
        end
        if (cmd.kind == PK_PRE) begin
          pre_idx_r <= pre_idx_r + 6'd1;
        end
      end
      if (cmd.finish) begin
        if (last_bit) begin
          bit_pos_r     <= '0;
          pulse_total_r <= '0;
        end else begin
          bit_pos_r <= bit_next;
          skip_r    <= err_dur || err_lim;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bit_r <= in_data_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (err_dur || err_lim) begin
        out_level_r    <= 1'b0;
        out_dur_r      <= '0;
        out_status_r   <= err_dur ? STAT_DUR : STAT_LIM;
        out_run_last_r <= 1'b1;
        out_done_r     <= 1'b1;
        out_cnt_r      <= pulse_total_r;
      end else begin
        out_level_r    <= pulse_level;
        out_dur_r      <= dur_full[DUR_W-1:0];
        out_status_r   <= STAT_OK;
        out_run_last_r <= (cmd.kind == PK_GRD) || (cmd.kind == PK_BLO && !last_bit);
        out_done_r     <= (cmd.kind == PK_GRD);
        out_cnt_r      <= pulse_total_r + 11'd1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_level         = out_level_r;
  assign out_length_us     = out_dur_r;
  assign out_status        = out_status_r;
  assign out_run_last      = out_run_last_r;
  assign out_frame_done    = out_done_r;
  assign out_pulses_so_far = out_cnt_r;

endmodule

// ===== src/rf_pwm_frame_pulse_encoder.sv =====
// Pulse-width encoder for an RF remote-control frame. Each accepted word is one data bit;
// the block answers with level and duration words: an alternating preamble starting HIGH
// and a LOW header before the first bit of a frame, a HIGH and a LOW pulse per bit, and
// a LOW guard pulse after the last bit. A pulse over 32767 us or a frame reaching
// PULSE_LIMIT pulses yields one error word that ends the frame, and the rest of that
// frame's bits are dropped, so a consumer discards any frame whose final status is not
// zero. The encoder works on one bit at a time: it takes the bit, then emits each of its
// pulses in turn through a single 12x8 multiplier into the output register, and it takes
// no new bit until the last pulse of the current one is emitted. A pulse waits while the
// output is stalled, and a dropped bit is taken without emitting any pulse.
// Configuration is written through cfg_index and cfg_data; the user must do so only while
// the encoder is idle, as the block itself does not enforce this.
module rf_pwm_frame_pulse_encoder import rfpe_pkg::*; #(
  parameter int PULSE_LIMIT = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_data_bit,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_level,
  output logic [DUR_W-1:0]  out_length_us,
  output logic [STAT_W-1:0] out_status,
  output logic              out_run_last,
  output logic              out_frame_done,
  output logic [CNT_W-1:0]  out_pulses_so_far,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [TE_W-1:0]   cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rfpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rfpe_dp #(
    .PULSE_LIMIT (PULSE_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_data_bit       (in_data_bit),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level         (out_level),
    .out_length_us     (out_length_us),
    .out_status        (out_status),
    .out_run_last      (out_run_last),
    .out_frame_done    (out_frame_done),
    .out_pulses_so_far (out_pulses_so_far)
  );

endmodule

// ===== src/rfpe_checker.sv =====
module rfpe_checker import rfpe_pkg::*; #(
  parameter int PULSE_LIMIT = 256
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_level,
  input logic [DUR_W-1:0]  out_length_us,
  input logic [STAT_W-1:0] out_status,
  input logic              out_run_last,
  input logic              out_frame_done,
  input logic [CNT_W-1:0]  out_pulses_so_far
);

  // An error word ends the frame and carries no pulse.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |->
      (out_frame_done && out_run_last && !out_level && out_length_us == '0))
    else $error("error word is malformed");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_run_last)
    else $error("frame end word does not close its bit");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OK) |->
      (out_pulses_so_far != '0 && out_pulses_so_far <= CNT_W'(PULSE_LIMIT)))
    else $error("pulse count out of range");

  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> in_stall)
    else $error("new bit taken while a bit is still being encoded");

endmodule

bind rf_pwm_frame_pulse_encoder rfpe_checker #(
  .PULSE_LIMIT (PULSE_LIMIT)
) u_rfpe_checker (.*);

// ===== dv/rf_pwm_frame_pulse_encoder_tb.sv =====
module rf_pwm_frame_pulse_encoder_tb;
  import rfpe_pkg::*;

  localparam int PULSE_LIMIT = 256;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_REPORTS = 40;

  localparam logic LVL_HIGH = 1'b1;
  localparam logic LVL_LOW = 1'b0;
  localparam logic [LEN_W-1:0] UNIT_ONE = 8'd1;
  localparam logic [LEN_W-1:0] UNIT_TWO = 8'd2;

  typedef struct packed {
    logic              level;
    logic [DUR_W-1:0]  length_us;
    logic [STAT_W-1:0] status;
    logic              run_last;
    logic              frame_done;
    logic [CNT_W-1:0]  pulses_so_far;
  } pulse_word_t;

  typedef struct packed {
    logic [CIDX_W-1:0] idx;
    logic [TE_W-1:0]   data;
  } cfg_word_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  class pwm_frame_tracker;
    logic [TE_W-1:0]   base_te;
    logic [PRE_W-1:0]  preamble_pulses;
    logic [LEN_W-1:0]  header_units;
    logic [LEN_W-1:0]  guard_units;
    logic [BITS_W-1:0] bits_per_frame;
    logic [BITS_W-1:0] next_bit_idx;
    logic [CNT_W-1:0]  frame_pulses;
    bit                dropping;
    pulse_word_t       pending_pulses[$];
    int                errors;
    int                checked;

    function new();
      base_te = TE_RST;
      preamble_pulses = PRE_RST;
      header_units = HDR_RST;
      guard_units = GRD_RST;
      bits_per_frame = BITS_RST;
      next_bit_idx = '0;
      frame_pulses = '0;
      dropping = 1'b0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [TE_W-1:0] data);
      case (idx)
        CFG_TE: base_te = data;
        CFG_PREAMBLE: preamble_pulses = data[PRE_W-1:0];
        CFG_HEADER: header_units = data[LEN_W-1:0];
        CFG_GUARD: guard_units = data[LEN_W-1:0];
        CFG_BITS: bits_per_frame = data[BITS_W-1:0];
        default: ;
      endcase
    endfunction

    // Queues one pulse, or the error word that replaces it. Returns 0 when the frame ends in error.
    function bit push_pulse(logic lvl, logic [LEN_W-1:0] units, logic done);
      logic [PROD_W-1:0] dur;
      pulse_word_t w;
      dur = PROD_W'(units) * PROD_W'(base_te);
      w = '0;
      w.frame_done = 1'b1;
      w.pulses_so_far = frame_pulses;
      if (dur > DUR_MAX) begin
        w.status = STAT_DUR;
        pending_pulses.push_back(w);
        return 1'b0;
      end
      if (frame_pulses >= PULSE_LIMIT) begin
        w.status = STAT_LIM;
        pending_pulses.push_back(w);
        return 1'b0;
      end
      frame_pulses = frame_pulses + 1'b1;
      w.level = lvl;
      w.length_us = dur[DUR_W-1:0];
      w.status = STAT_OK;
      w.frame_done = done;
      w.pulses_so_far = frame_pulses;
      pending_pulses.push_back(w);
      return 1'b1;
    endfunction

    function void encode_bit(logic b);
      logic [BITS_W-1:0] nxt;
      bit last_bit;
      bit ok;
      int np;
      int first_new;
      pulse_word_t tail;
      nxt = next_bit_idx + 1'b1;
      last_bit = (nxt == bits_per_frame);
      ok = 1'b1;
      first_new = pending_pulses.size();
      if (dropping) begin
        if (last_bit) begin
          next_bit_idx = '0;
          frame_pulses = '0;
          dropping = 1'b0;
        end else begin
          next_bit_idx = nxt;
        end
        return;
      end
      if (next_bit_idx == '0) begin
        np = (preamble_pulses > PREAMBLE_MAX) ? int'(PREAMBLE_MAX) : int'(preamble_pulses);
        frame_pulses = '0;
        for (int i = 0; i < np && ok; i++) begin
          ok = push_pulse((i % 2 == 0) ? LVL_HIGH : LVL_LOW, UNIT_ONE, 1'b0);
        end
        if (ok) ok = push_pulse(LVL_LOW, header_units, 1'b0);
      end
      if (ok) ok = push_pulse(LVL_HIGH, b ? UNIT_TWO : UNIT_ONE, 1'b0);
      if (ok) ok = push_pulse(LVL_LOW, b ? UNIT_ONE : UNIT_TWO, 1'b0);
      if (ok && last_bit) ok = push_pulse(LVL_LOW, guard_units, 1'b1);
      if (last_bit) begin
        next_bit_idx = '0;
        frame_pulses = '0;
      end else begin
        next_bit_idx = nxt;
        if (!ok) dropping = 1'b1;
      end
      if (pending_pulses.size() > first_new) begin
        tail = pending_pulses.pop_back();
        tail.run_last = 1'b1;
        pending_pulses.push_back(tail);
      end
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH word %0d: %0s", checked, msg);
    endtask

    task compare_pulse(input pulse_word_t got);
      pulse_word_t want;
      checked++;
      if (pending_pulses.size() == 0) begin
        report($sformatf("unexpected word level=%0d dur=%0d status=%0d",
                         got.level, got.length_us, got.status));
        return;
      end
      want = pending_pulses.pop_front();
      if (got.level !== want.level)
        report($sformatf("level %0d, expected %0d", got.level, want.level));
      if (got.length_us !== want.length_us)
        report($sformatf("length_us %0d, expected %0d", got.length_us, want.length_us));
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %0d, expected %0d", got.run_last, want.run_last));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done %0d, expected %0d", got.frame_done, want.frame_done));
      if (got.pulses_so_far !== want.pulses_so_far)
        report($sformatf("pulses_so_far %0d, expected %0d", got.pulses_so_far,
                         want.pulses_so_far));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_data_bit = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_level;
  logic [DUR_W-1:0]  out_length_us;
  logic [STAT_W-1:0] out_status;
  logic              out_run_last;
  logic              out_frame_done;
  logic [CNT_W-1:0]  out_pulses_so_far;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [TE_W-1:0]   cfg_data = '0;

  pwm_frame_tracker tracker;
  cfg_word_t        cfg_backlog[$];
  pulse_word_t      observed_word;
  int               burst_left = 0;
  int               cycle_count = 0;
  int               hold_requests = 0;
  int               hold_granted = 0;
  int               rx_hold_left = 0;
  int               rx_mode_left = 0;
  int               rx_tick = 0;
  rx_mode_t         rx_mode = RX_FREE;

  rf_pwm_frame_pulse_encoder #(.PULSE_LIMIT(PULSE_LIMIT)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_bit       (in_data_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level         (out_level),
    .out_length_us     (out_length_us),
    .out_status        (out_status),
    .out_run_last      (out_run_last),
    .out_frame_done    (out_frame_done),
    .out_pulses_so_far (out_pulses_so_far),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      observed_word = {out_level, out_length_us, out_status, out_run_last, out_frame_done,
                       out_pulses_so_far};
      tracker.compare_pulse(observed_word);
    end
  end

  // The receiver mixes free, light, heavy and periodic stall patterns, plus an occasional
  // long hold-off that lets the encoder back up into its input.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_requests != hold_granted) begin
      hold_granted = hold_requests;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(16, 160);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (rx_tick % 5 < 2);
      endcase
    end
  end

  task automatic send_bit(input logic b);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_data_bit <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.encode_bit(b);
    burst_left--;
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic end_stream();
    if (burst_left != 0) begin
      in_valid <= 1'b0;
      burst_left = 0;
    end
  endtask

  task automatic send_bits(input logic [7:0] pattern, input int count);
    for (int i = 0; i < count; i++) send_bit(pattern[i]);
    end_stream();
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_bit(1'($urandom_range(0, 1)));
    end_stream();
  endtask

  task automatic drain_pulses();
    while (tracker.pending_pulses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void stage_reg(logic [CIDX_W-1:0] idx, logic [TE_W-1:0] value, int width);
    logic [TE_W-1:0] noise;
    cfg_word_t w;
    noise = TE_W'($urandom);
    w.idx = idx;
    w.data = (width >= TE_W) ? value : ((noise << width) | value);
    cfg_backlog.push_back(w);
  endfunction

  function automatic void stage_all(logic [TE_W-1:0] te, logic [PRE_W-1:0] pre,
                                    logic [LEN_W-1:0] hdr, logic [LEN_W-1:0] grd,
                                    logic [BITS_W-1:0] frame_len);
    stage_reg(CFG_TE, te, TE_W);
    stage_reg(CFG_PREAMBLE, TE_W'(pre), PRE_W);
    stage_reg(CFG_HEADER, TE_W'(hdr), LEN_W);
    stage_reg(CFG_GUARD, TE_W'(grd), LEN_W);
    stage_reg(CFG_BITS, TE_W'(frame_len), BITS_W);
  endfunction

  task automatic commit_writes();
    cfg_word_t w;
    while (cfg_backlog.size() > 0) begin
      w = cfg_backlog.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_reg(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic reconfigure(input logic [TE_W-1:0] te, input logic [PRE_W-1:0] pre,
                             input logic [LEN_W-1:0] hdr, input logic [LEN_W-1:0] grd,
                             input logic [BITS_W-1:0] frame_len);
    drain_pulses();
    stage_all(te, pre, hdr, grd, frame_len);
    commit_writes();
  endtask

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'd255;
      2, 3: return LEN_W'($urandom_range(1, 255));
      default: return LEN_W'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic random_phase();
    int frame_len;
    logic [TE_W-1:0] te;
    frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    case ($urandom_range(0, 4))
      0: te = 12'd4095;
      1: te = 12'd1;
      2: te = TE_W'($urandom_range(0, 4095));
      default: te = TE_W'($urandom_range(1, 300));
    endcase
    reconfigure(te, PRE_W'($urandom_range(0, 63)), pick_len(), pick_len(), BITS_W'(frame_len));
    send_random(frame_len * $urandom_range(1, 3));
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, then a shorter frame length written in the middle of the frame.
    send_bits(8'b101, 3);
    drain_pulses();
    stage_reg(CFG_BITS, TE_W'(4), BITS_W);
    commit_writes();
    send_bits(8'b0, 1);

    reconfigure(12'd4095, 6'd0, 8'd1, 8'd1, 7'd3);
    send_bits(8'b101, 3);
    // Zero time element and zero lengths, preamble longer than the cap.
    reconfigure(12'd0, 6'd63, 8'd0, 8'd0, 7'd2);
    send_bits(8'b10, 2);
    // Header too long: error word, then the rest of the frame is dropped.
    reconfigure(12'd4095, 6'd2, 8'd255, 8'd1, 7'd4);
    send_bits(8'b0011, 4);
    // One-bit frames whose guard is too long.
    reconfigure(12'd1000, 6'd1, 8'd1, 8'd255, 7'd1);
    send_bits(8'b10, 2);
    drain_pulses();
    stage_all(12'd1, 6'd48, 8'd255, 8'd255, 7'd2);
    for (int i = int'(CFG_BITS) + 1; i < (1 << CIDX_W); i++)
      stage_reg(CIDX_W'(i), TE_W'($urandom), TE_W);
    commit_writes();
    send_bits(8'b01, 2);

    for (int p = 0; p < 8; p++) begin
      random_phase();
      if (p == 1) begin
        // Frame length cut below the current position: the bit counter wraps, the pulse
        // limit is reached on the way and the remaining bits are dropped.
        reconfigure(TE_W'($urandom_range(1, 50)), 6'd48, LEN_W'($urandom_range(1, 20)),
                    LEN_W'($urandom_range(1, 20)), 7'd20);
        send_random(10);
        drain_pulses();
        stage_reg(CFG_BITS, TE_W'(5), BITS_W);
        commit_writes();
        send_random(123);
      end
      if (p == 3) begin
        // The guard is both too long and over the pulse limit; the duration check wins.
        reconfigure(12'd200, 6'd47, 8'd1, 8'd255, 7'd104);
        hold_requests++;
        send_random(104);
      end
      if (p == 5) begin
        // A frame length of zero means 128 bits; the limit hits on the last bit.
        reconfigure(TE_W'($urandom_range(1, 100)), 6'd0, LEN_W'($urandom_range(1, 30)),
                    LEN_W'($urandom_range(1, 30)), 7'd0);
        hold_requests++;
        send_random(128);
      end
    end

    drain_pulses();
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
